// File: design/lidfp_pkg.sv
`default_nettype none

package lidfp_pkg;

  localparam int unsigned SEGMENTS = 16;
  localparam int unsigned SEG_W = 4;
  localparam int unsigned POS_W = 3;
  localparam int unsigned IDX_W = 11;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] DIST_NONE = 16'hFFFF;

  localparam logic [15:0] NEAR_RANGE_RST = 16'd125;
  localparam logic [9:0] AMP_THRESH_RST = 10'd50;
  localparam logic [15:0] MIN_DIST_RST = 16'd30;

  localparam logic [POS_W-1:0] POS_LAST = 3'd4;
  localparam logic [IDX_W-1:0] HDR_LEN = 11'd3;
  localparam logic [IDX_W-1:0] COUNT_IDX = 11'd2;
  localparam logic [IDX_W-1:0] TAIL_OFS = 11'd9;
  localparam logic [SEG_W-1:0] SEG_LAST = 4'd15;

  typedef enum logic [1:0] {
    REG_NEAR_RANGE = 2'd0,
    REG_AMP_THRESH = 2'd1,
    REG_MIN_DIST   = 2'd2
  } reg_index_t;

  typedef enum logic [1:0] {
    CMD_CLEAR,
    CMD_DET,
    CMD_END
  } cmd_kind_t;

  typedef enum logic {
    BK_IDLE,
    BK_EMIT
  } back_state_t;

  typedef struct packed {
    logic       func;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic             status;
    logic [SEG_W-1:0] segment;
    logic             found;
    logic [15:0]      distance;
    logic [9:0]       amplitude;
    logic             last;
  } out_item_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [SEG_W-1:0] seg;
    logic [15:0]      distance;
    logic [9:0]       amp;
    logic             crc_ok;
  } cmd_t;

  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: design/lidfp_front.sv
`default_nettype none

module lidfp_front
  import lidfp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire in_item_t   in_item,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [15:0] cfg_data,
  output logic            cmd_push,
  output cmd_t            cmd_data,
  input  wire logic       cmd_full
);

  logic [15:0] near_range;
  logic [9:0] amp_thresh;
  logic [15:0] min_dist;

  logic frame_active, frame_active_next;
  logic [IDX_W-1:0] byte_count, byte_count_next;
  logic [IDX_W-1:0] det_end, det_end_next;
  logic [IDX_W-1:0] tail_idx, tail_idx_next;
  logic [POS_W-1:0] pos, pos_next;
  logic [15:0] crc_value, crc_next;
  logic [7:0] held_lo, held_lo_next;
  logic [3:0][7:0] det_bytes, det_bytes_next;

  logic accept;
  logic [7:0] b;
  logic [15:0] crc_upd;
  logic [IDX_W-1:0] times5;
  logic [15:0] det_dist;
  logic [9:0] amp;
  logic keep;

  assign in_ready = !cmd_full;
  assign cfg_ready = 1'b1;
  assign accept = in_valid && in_ready;
  assign b = in_item.data_byte;
  assign crc_upd = crc_step(crc_value, b);
  assign times5 = ({3'b000, b} << 2) + {3'b000, b};
  assign det_dist = {det_bytes[1], det_bytes[0]};
  assign amp = {det_bytes[3], det_bytes[2][7:6]};
  assign keep = (det_dist > near_range || amp > amp_thresh) && det_dist > min_dist;

  always_comb begin
    frame_active_next = frame_active;
    byte_count_next = byte_count;
    det_end_next = det_end;
    tail_idx_next = tail_idx;
    pos_next = pos;
    crc_next = crc_value;
    held_lo_next = held_lo;
    det_bytes_next = det_bytes;
    cmd_push = 1'b0;
    cmd_data = '{kind: CMD_CLEAR, seg: ~in_item.data_byte[7:4], distance: det_dist,
                 amp: amp, crc_ok: ({b, held_lo} == crc_value)};
    if (accept) begin
      if (!in_item.func) begin
        frame_active_next = 1'b1;
        byte_count_next = '0;
        crc_next = CRC_INIT;
        held_lo_next = '0;
        det_bytes_next = '0;
        pos_next = '0;
        cmd_push = 1'b1;
      end else if (frame_active) begin
        byte_count_next = byte_count + 1'b1;
        if (byte_count < HDR_LEN) begin
          crc_next = crc_upd;
          pos_next = '0;
          if (byte_count == COUNT_IDX) begin
            det_end_next = HDR_LEN + times5;
            tail_idx_next = times5 + TAIL_OFS;
          end
        end else begin
          if (byte_count < det_end) begin
            if (pos != POS_LAST) begin
              det_bytes_next[pos[1:0]] = b;
              pos_next = pos + 1'b1;
            end else begin
              pos_next = '0;
              if (keep) begin
                cmd_push = 1'b1;
                cmd_data.kind = CMD_DET;
              end
            end
          end
          if (byte_count < tail_idx) begin
            crc_next = crc_upd;
          end else if (byte_count == tail_idx) begin
            held_lo_next = b;
          end else begin
            // last byte closes the frame
            frame_active_next = 1'b0;
            cmd_push = 1'b1;
            cmd_data.kind = CMD_END;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      near_range <= NEAR_RANGE_RST;
      amp_thresh <= AMP_THRESH_RST;
      min_dist <= MIN_DIST_RST;
      frame_active <= 1'b0;
      byte_count <= '0;
      det_end <= '0;
      tail_idx <= '0;
      pos <= '0;
      crc_value <= CRC_INIT;
      held_lo <= '0;
      det_bytes <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_NEAR_RANGE: near_range <= cfg_data;
          REG_AMP_THRESH: amp_thresh <= cfg_data[9:0];
          REG_MIN_DIST:   min_dist <= cfg_data;
          default: ;
        endcase
      end
      frame_active <= frame_active_next;
      byte_count <= byte_count_next;
      det_end <= det_end_next;
      tail_idx <= tail_idx_next;
      pos <= pos_next;
      crc_value <= crc_next;
      held_lo <= held_lo_next;
      det_bytes <= det_bytes_next;
    end
  end

endmodule

`default_nettype wire

// File: design/lidfp_queue.sv
`default_nettype none

module lidfp_queue
  import lidfp_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_data,
  output logic      full,
  input  wire logic pop,
  output logic      not_empty,
  output cmd_t      head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  cmd_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic do_push, do_pop;

  assign full = (count == CNT_FULL);
  assign not_empty = (count != '0);
  assign head = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: design/lidfp_back.sv
`default_nettype none

module lidfp_back
  import lidfp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cmd_valid,
  input  wire cmd_t cmd,
  output logic      cmd_pop,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_item_t out_item
);

  back_state_t state, state_next;
  logic [SEG_W-1:0] cnt, cnt_next;
  logic [15:0] seg_dist [SEGMENTS];
  logic [9:0] seg_amp [SEGMENTS];
  logic [SEGMENTS-1:0] seg_found;

  logic slot_free;
  logic [SEG_W-1:0] rd_idx;
  logic rd_found;
  logic [15:0] rd_dist;
  logic [9:0] rd_amp;
  logic do_clear, do_update, load;
  out_item_t load_data;

  assign slot_free = !out_valid || out_ready;
  assign rd_idx = (state == BK_EMIT) ? cnt : cmd.seg;
  assign rd_found = seg_found[rd_idx];
  assign rd_dist = seg_dist[rd_idx];
  assign rd_amp = seg_amp[rd_idx];

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (cmd_valid && slot_free && cmd.kind == CMD_END && cmd.crc_ok) begin
          state_next = BK_EMIT;
        end
      end
      BK_EMIT: begin
        if (slot_free && cnt == SEG_LAST) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop = 1'b0;
    do_clear = 1'b0;
    do_update = 1'b0;
    load = 1'b0;
    cnt_next = cnt;
    load_data = '{status: 1'b1, segment: '0, found: 1'b0, distance: DIST_NONE,
                  amplitude: '0, last: 1'b1};
    unique case (state)
      BK_IDLE: begin
        cnt_next = '0;
        if (cmd_valid) begin
          unique case (cmd.kind)
            CMD_CLEAR: begin
              cmd_pop = 1'b1;
              do_clear = 1'b1;
            end
            CMD_DET: begin
              cmd_pop = 1'b1;
              // later detection wins on equal distance
              do_update = !rd_found || cmd.distance <= rd_dist;
            end
            CMD_END: begin
              if (slot_free) begin
                cmd_pop = 1'b1;
                load = !cmd.crc_ok;
              end
            end
            default: cmd_pop = 1'b1;
          endcase
        end
      end
      BK_EMIT: begin
        if (slot_free) begin
          load = 1'b1;
          cnt_next = cnt + 1'b1;
          load_data = '{status: 1'b0, segment: cnt, found: rd_found,
                        distance: rd_found ? rd_dist : DIST_NONE,
                        amplitude: rd_found ? rd_amp : '0,
                        last: (cnt == SEG_LAST)};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_update) begin
      seg_dist[cmd.seg] <= cmd.distance;
      seg_amp[cmd.seg] <= cmd.amp;
    end
    if (load) begin
      out_item <= load_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      cnt <= '0;
      seg_found <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      if (do_clear) begin
        seg_found <= '0;
      end else if (do_update) begin
        seg_found[cmd.seg] <= 1'b1;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// File: design/lidar_detection_frame_parser.sv
// range sensor reply frame parser
// in channel (in_valid/in_ready/in_item): func 0 opens a new frame, func 1
// carries one received byte. one item is taken per cycle while the command
// queue between the byte parser and the result engine has room.
// the parser runs the crc and detection assembly at one byte per cycle and
// queues a command on frame start, on each kept detection and on the last byte.
// out channel (out_valid/out_ready/out_item): at frame end either one crc error
// result or sixteen segment reports, segment 0 first, last set on the final one.
// with an empty queue a crc error result passes through the queue and the
// output register; for a good frame the engine first enters its emit state and
// then sends the reports one per cycle while the receiver is ready, stepping
// through the segment table by its single read port.
// cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) is always ready:
// index 0 near range, 1 amplitude threshold, 2 minimum distance.
// reset restores register defaults, closes any frame and empties the queue.
// when the receiver stalls, the held result stays put, the engine waits,
// the queue fills and in_ready drops once it is full.
`default_nettype none

module lidar_detection_frame_parser
  import lidfp_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_item_t    in_item,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_item_t        out_item,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  logic cmd_push, cmd_full, cmd_pop, cmd_valid;
  cmd_t cmd_in, cmd_head;

  lidfp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_push  (cmd_push),
    .cmd_data  (cmd_in),
    .cmd_full  (cmd_full)
  );

  lidfp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd_push),
    .push_data (cmd_in),
    .full      (cmd_full),
    .pop       (cmd_pop),
    .not_empty (cmd_valid),
    .head      (cmd_head)
  );

  lidfp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd_head),
    .cmd_pop   (cmd_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

// File: dv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lidfp_pkg::*;

  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam int DRAIN_CYCLES = 40;

  class frame_scoreboard;
    logic [15:0] near_rng;
    logic [9:0]  amp_thr;
    logic [15:0] min_rng;

    logic [10:0] byte_idx;
    bit          open;
    logic [7:0]  det_count;
    logic [15:0] crc;
    logic [15:0] tail;
    logic [31:0] det_bytes;
    logic [15:0] best_rng [SEGMENTS];
    logic [9:0]  best_amp [SEGMENTS];
    bit          seg_hit [SEGMENTS];

    out_item_t   pending_reports [$];
    int          mismatches;

    function new();
      near_rng = NEAR_RANGE_RST;
      amp_thr = AMP_THRESH_RST;
      min_rng = MIN_DIST_RST;
      open = 1'b0;
      mismatches = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      byte_idx = '0;
      det_count = '0;
      crc = CRC_INIT;
      tail = '0;
      det_bytes = '0;
      for (int k = 0; k < SEGMENTS; k++) begin
        best_rng[k] = DIST_NONE;
        best_amp[k] = '0;
        seg_hit[k] = 1'b0;
      end
    endfunction

    function logic [15:0] crc_next(logic [15:0] c, logic [7:0] b);
      logic [15:0] r;
      r = c ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
        r = r[0] ? ((r >> 1) ^ 16'hA001) : (r >> 1);
      end
      return r;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] data);
      case (idx)
        REG_NEAR_RANGE: near_rng = data;
        REG_AMP_THRESH: amp_thr = data[9:0];
        REG_MIN_DIST:   min_rng = data;
        default: ;
      endcase
    endfunction

    function int outstanding();
      return pending_reports.size();
    endfunction

    function void note_request(in_item_t it);
      logic [10:0] idx;
      logic [7:0]  b;
      int          flen, det_end, pos;
      logic [15:0] rng;
      logic [9:0]  amp;
      logic [3:0]  seg;
      bit          keep;
      out_item_t   rep;
      b = it.data_byte;
      if (!it.func) begin
        clear_frame();
        open = 1'b1;
        return;
      end
      if (!open) return;
      idx = byte_idx;
      byte_idx = byte_idx + 11'd1;
      if (idx < 3) begin
        if (idx == 2) det_count = b;
        crc = crc_next(crc, b);
        return;
      end
      flen = int'(det_count) * 5 + 11;
      det_end = 3 + int'(det_count) * 5;
      if (int'(idx) < det_end) begin
        pos = (int'(idx) - 3) % 5;
        if (pos < 4) begin
          det_bytes[pos*8 +: 8] = b;
        end else begin
          // fifth byte of a detection: its top nibble selects the segment
          rng = det_bytes[15:0];
          amp = {det_bytes[31:24], det_bytes[23:22]};
          seg = 4'd15 - b[7:4];
          keep = (rng > near_rng || amp > amp_thr) && rng > min_rng;
          if (keep && (!seg_hit[seg] || rng <= best_rng[seg])) begin
            best_rng[seg] = rng;
            best_amp[seg] = amp;
            seg_hit[seg] = 1'b1;
          end
        end
      end
      if (int'(idx) < flen - 2) begin
        crc = crc_next(crc, b);
        return;
      end
      if (int'(idx) == flen - 2) begin
        tail[7:0] = b;
        return;
      end
      tail[15:8] = b;
      open = 1'b0;
      if (tail != crc) begin
        rep.status = 1'b1;
        rep.segment = '0;
        rep.found = 1'b0;
        rep.distance = DIST_NONE;
        rep.amplitude = '0;
        rep.last = 1'b1;
        pending_reports.push_back(rep);
        return;
      end
      for (int k = 0; k < SEGMENTS; k++) begin
        rep.status = 1'b0;
        rep.segment = k[3:0];
        rep.found = seg_hit[k];
        rep.distance = seg_hit[k] ? best_rng[k] : DIST_NONE;
        rep.amplitude = seg_hit[k] ? best_amp[k] : '0;
        rep.last = (k == SEGMENTS - 1);
        pending_reports.push_back(rep);
      end
    endfunction

    function string describe(out_item_t r);
      return $sformatf("st=%0d seg=%0d fnd=%0d rng=%0d amp=%0d lst=%0d",
                       r.status, r.segment, r.found, r.distance, r.amplitude, r.last);
    endfunction

    function void check_report(out_item_t got);
      out_item_t want;
      if (pending_reports.size() == 0) begin
        if (mismatches < 10) $display("unexpected report: %s", describe(got));
        mismatches++;
        return;
      end
      want = pending_reports.pop_front();
      if (got.status !== want.status || got.segment !== want.segment ||
          got.found !== want.found || got.distance !== want.distance ||
          got.amplitude !== want.amplitude || got.last !== want.last) begin
        if (mismatches < 10) begin
          $display("report differs at %0t: want %s got %s", $realtime, describe(want),
                   describe(got));
        end
        mismatches++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_item;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  frame_scoreboard sb = new();
  int send_idle_pct;
  int recv_idle_pct;
  int frame_bytes_sent;

  lidar_detection_frame_parser uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("lidar_detection_frame_parser: mismatch");
    $finish;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_report(out_item);
  end

  // valid stays up from the previous request unless an idle gap is rolled
  task automatic push_request(input logic f, input logic [7:0] b);
    in_item_t it;
    it.func = f;
    it.data_byte = b;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_request(it);
    @(negedge clk);
  endtask

  task automatic set_config(input logic [15:0] nr, input logic [15:0] thr_data,
                            input logic [15:0] md);
    logic [1:0]  idx_list [4];
    logic [15:0] val_list [4];
    int          i;
    idx_list[0] = REG_SPARE;      val_list[0] = 16'($urandom);
    idx_list[1] = REG_NEAR_RANGE; val_list[1] = nr;
    idx_list[2] = REG_AMP_THRESH; val_list[2] = thr_data;
    idx_list[3] = REG_MIN_DIST;   val_list[3] = md;
    for (i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx_list[i];
      cfg_data <= val_list[i];
      do @(posedge clk); while (!cfg_ready);
      sb.set_reg(idx_list[i], val_list[i]);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic drain_phase();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // start, body, then the two crc bytes; cut >= 0 abandons the frame early
  task automatic send_frame(input logic [7:0] body [$], input bit good_crc, input int cut);
    logic [15:0] crc;
    logic [7:0]  bytes [$];
    int          i;
    crc = CRC_INIT;
    for (i = 0; i < body.size(); i++) crc = sb.crc_next(crc, body[i]);
    if (!good_crc) crc ^= 16'h1 << $urandom_range(15);
    bytes = body;
    bytes.push_back(crc[7:0]);
    bytes.push_back(crc[15:8]);
    push_request(1'b0, 8'($urandom));
    frame_bytes_sent++;
    for (i = 0; i < bytes.size(); i++) begin
      if (cut >= 0 && i >= cut) break;
      push_request(1'b1, bytes[i]);
      frame_bytes_sent++;
    end
  endtask

  // distances cluster on the threshold edges so both sides of each compare occur
  function automatic logic [15:0] pick_range(input logic [15:0] prev);
    case ($urandom_range(9))
      0: return 16'd0;
      1: return sb.min_rng;
      2: return sb.min_rng + 16'd1;
      3: return sb.near_rng;
      4: return sb.near_rng + 16'd1;
      5: return DIST_NONE;
      6: return prev;
      7: return sb.near_rng - 16'd1;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [9:0] pick_amplitude();
    case ($urandom_range(5))
      0: return 10'd0;
      1: return 10'h3FF;
      2: return sb.amp_thr;
      3: return sb.amp_thr + 10'd1;
      default: return 10'($urandom);
    endcase
  endfunction

  task automatic send_random_frame(input int n_det, input bit good_crc, input bit abandon);
    logic [7:0]  body [$];
    logic [15:0] rng, prev;
    logic [9:0]  amp;
    logic [3:0]  seg_hi;
    body.push_back(8'($urandom));
    body.push_back(8'($urandom));
    body.push_back(8'(n_det));
    prev = 16'($urandom);
    repeat (n_det) begin
      rng = pick_range(prev);
      amp = pick_amplitude();
      prev = rng;
      // half the detections crowd into a few segments to force competition
      seg_hi = ($urandom_range(1) == 1) ? 4'($urandom_range(2)) : 4'($urandom);
      body.push_back(rng[7:0]);
      body.push_back(rng[15:8]);
      body.push_back({amp[1:0], 6'($urandom)});
      body.push_back(amp[9:2]);
      body.push_back({seg_hi, 4'($urandom)});
    end
    repeat (6) body.push_back(8'($urandom));
    send_frame(body, good_crc, abandon ? $urandom_range(body.size() + 1) : -1);
  endtask

  task automatic run_traffic(input int n_items);
    int goal;
    int roll;
    goal = frame_bytes_sent + n_items;
    while (frame_bytes_sent < goal) begin
      roll = $urandom_range(99);
      if (roll < 55) begin
        send_random_frame($urandom_range(3), $urandom_range(7) != 0, 1'b0);
      end else if (roll < 70) begin
        send_random_frame($urandom_range(4, 20), $urandom_range(7) != 0, 1'b0);
      end else if (roll < 80) begin
        send_random_frame($urandom_range(6), 1'b1, 1'b1);
      end else if (roll < 90) begin
        // trailing bytes past the end of a complete frame
        send_random_frame($urandom_range(2), 1'b1, 1'b0);
        repeat ($urandom_range(1, 4)) push_request(1'b1, 8'($urandom));
      end else begin
        repeat ($urandom_range(1, 10)) push_request($urandom_range(9) != 0, 8'($urandom));
      end
    end
  endtask

  initial begin
    logic [7:0] body [$];
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    out_ready = 1'b0;
    frame_bytes_sent = 0;
    send_idle_pct = 27;
    recv_idle_pct = 51;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // bytes before any frame start are dropped
    push_request(1'b1, 8'h00);
    push_request(1'b1, 8'hFF);
    // default registers: a detection at full range with full amplitude in
    // segment 15, then a weak near one there that must not displace it
    body = '{8'h11, 8'h04, 8'd2,
             8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00,
             8'd100, 8'd0, 8'h80, 8'd12, 8'h0F,
             8'h00, 8'h5A, 8'hA5, 8'hFF, 8'h3C, 8'hC3};
    send_frame(body, 1'b1, -1);
    run_traffic(80);
    drain_phase();

    set_config(16'hFFFF, 16'hFC00, 16'h0000);
    run_traffic(80);
    drain_phase();

    send_idle_pct = 51;
    recv_idle_pct = 27;
    set_config(16'h0000, 16'hFFFF, 16'hFFFF);
    run_traffic(40);
    drain_phase();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_config(16'($urandom_range(50, 3000)), {6'($urandom), 10'($urandom)},
               16'($urandom_range(500)));
    run_traffic(100);
    drain_phase();

    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("lidar_detection_frame_parser: match");
    end else begin
      $display("lidar_detection_frame_parser: mismatch");
    end
    $finish;
  end

endmodule
